// ===== design/fsgs_pkg.sv =====
// Shared constants, types and helpers for the five-servo gesture sequencer.
// Depends on nothing; the top level imports it.

package fsgs_pkg;

    localparam int FINGER_COUNT    = 5;
    localparam int GOODBYE_REPEATS = 3;

    localparam int ANGLE_W    = 8;
    localparam int OFFSET_W   = 7;
    localparam int POS_W      = 11;
    localparam int GESTURE_W  = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;

    typedef logic signed [POS_W-1:0]    pos_t;
    typedef logic signed [OFFSET_W-1:0] offset_t;
    typedef logic [ANGLE_W-1:0]         angle_t;

    // Gesture codes carried in the command item.
    localparam logic [GESTURE_W-1:0] GEST_OPEN      = 3'd0;
    localparam logic [GESTURE_W-1:0] GEST_CLOSE     = 3'd1;
    localparam logic [GESTURE_W-1:0] GEST_HELLO     = 3'd2;
    localparam logic [GESTURE_W-1:0] GEST_HANDSHAKE = 3'd3;
    localparam logic [GESTURE_W-1:0] GEST_NO        = 3'd4;
    localparam logic [GESTURE_W-1:0] GEST_GOODBYE   = 3'd5;

    // Gesture phases.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_OPEN    = 2'd1;
    localparam logic [1:0] PH_CLOSE   = 2'd2;
    localparam logic [1:0] PH_PATTERN = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_START_ANGLE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_SPAN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_THUMB  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_INDEX  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_MIDDLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_RING   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_PINKY  = 3'd6;

    localparam angle_t  RESET_START_ANGLE = 8'd45;
    localparam angle_t  RESET_ANGLE_SPAN  = 8'd90;
    localparam offset_t RESET_OFFSET [FINGER_COUNT] = '{
        7'sd20, -7'sd12, 7'sd7, 7'sd2, -7'sd6
    };

    localparam pos_t POS_MAX   = 11'sd1023;
    localparam pos_t ANGLE_TOP = 11'sd180;

    // Rest angle of a finger: base angle plus its signed offset.
    function automatic pos_t rest_angle(input angle_t start, input offset_t offset);
        pos_t a;
        pos_t b;
        a = $signed({3'b000, start});
        b = $signed({{(POS_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});
        return a + b;
    endfunction

    // Servo output: position clamped to 0..180 degrees.
    function automatic angle_t clamp_angle(input pos_t p);
        angle_t a;
        if (p < 0) begin
            a = '0;
        end else if (p > ANGLE_TOP) begin
            a = ANGLE_TOP[ANGLE_W-1:0];
        end else begin
            a = p[ANGLE_W-1:0];
        end
        return a;
    endfunction

endpackage

// ===== design/five_servo_gesture_sequencer.sv =====
// Top level of the five-servo gesture sequencer: gesture state, finger positions
// and the output register. Depends on fsgs_pkg.
//
// Usage: the input stream carries one item per command or motion tick. s_tuser
// selects the kind (0 = tick, 1 = gesture command) and s_tdata[2:0] holds the
// gesture code. A command starts open, close, hello, handshake, no or goodbye;
// it is rejected when a gesture is already running or the code is unknown.
// Every tick advances the running gesture by one motion step and moves each
// finger by at most one degree.
// Each input item produces exactly one result item on the master stream: the
// five servo angles clamped to 0..180 and the busy, rejected and finished flags.
// The result appears on m_tvalid in the cycle after the item is accepted. The
// throughput is one item per cycle while the receiver keeps up, set by the single
// pass of compare and increment logic between the input and the result register.
// When the receiver stalls, the result register holds its item and s_tready
// drops until that item is taken; it stays high while the register is empty
// or being drained in the same cycle.
// Reset returns the configuration registers to their defaults, places every
// finger at its rest angle and leaves the block idle with no pending result.
// Configuration writes are taken at any edge with cfg_we high and are meant
// for idle periods only.

module five_servo_gesture_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input item: tdata = {gesture[2:0]} from bit 0, zero padded; tuser = operation.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fsgs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    // Result item, from bit 0: angle_thumb[7:0], angle_index[7:0],
    // angle_middle[7:0], angle_ring[7:0], angle_pinky[7:0], busy_res,
    // rejected, finished, zero padding.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fsgs_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [fsgs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fsgs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import fsgs_pkg::*;

    // Configuration registers.
    angle_t  start_angle_reg;
    angle_t  angle_span_reg;
    offset_t offset_reg [FINGER_COUNT];

    // Gesture state.
    pos_t                 position_reg  [FINGER_COUNT];
    pos_t                 position_next [FINGER_COUNT];
    logic [GESTURE_W-1:0] active_reg, active_next;
    logic [1:0]           phase_reg, phase_next;
    logic [7:0]           step_reg, step_next;
    logic [1:0]           mod3_reg, mod3_next;     // step_reg modulo 3
    logic [1:0]           repeat_reg, repeat_next;
    logic                 running_reg, running_next;

    // Result register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic accept;
    logic rejected;
    logic finished;
    pos_t rest      [FINGER_COUNT];
    pos_t lim_close [FINGER_COUNT];
    logic [M_TDATA_W-1:0] out_data_next;

    // The result register frees up whenever it is empty or being read.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Rest and full-close limits follow the registers live.
    always_comb begin
        for (int f = 0; f < FINGER_COUNT; f++) begin
            rest[f]      = rest_angle(start_angle_reg, offset_reg[f]);
            lim_close[f] = rest[f] + $signed({3'b000, angle_span_reg});
        end
    end

    always_comb begin
        logic                  closing;
        logic                  limit_done;
        logic                  all_there;
        logic                  step_end;
        logic [8:0]            step_inc;
        logic [1:0]            mod3_inc;
        logic [1:0]            repeat_inc;
        logic [7:0]            step_after;
        logic [FINGER_COUNT-1:0] inc_mask;
        logic                  e2, e3, e4;
        pos_t                  lim;

        for (int f = 0; f < FINGER_COUNT; f++) begin
            position_next[f] = position_reg[f];
        end
        active_next  = active_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        mod3_next    = mod3_reg;
        repeat_next  = repeat_reg;
        running_next = running_reg;
        rejected     = 1'b0;
        finished     = 1'b0;

        closing    = (phase_reg == PH_CLOSE);
        limit_done = 1'b0;
        all_there  = 1'b1;
        step_end   = (step_reg >= angle_span_reg);
        step_inc   = {1'b0, step_reg} + 9'd1;
        mod3_inc   = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
        repeat_inc = repeat_reg + 2'd1;
        step_after = step_reg;
        lim        = '0;

        // Pattern step index is step_reg + 1; these test its divisibility.
        e2 = step_reg[0];
        e4 = (step_reg[1:0] == 2'b11);
        e3 = (mod3_reg == 2'd2);
        case (active_reg)
            GEST_HELLO:     inc_mask = 5'b00001;
            GEST_HANDSHAKE: inc_mask = {e2, e3, e4, e4, e2};
            GEST_NO:        inc_mask = {1'b1, 1'b1, e2, e2, 1'b1};
            default:        inc_mask = 5'b11110;
        endcase

        if (accept) begin
            if (s_tuser) begin
                // Gesture command.
                if (running_reg || s_tdata[GESTURE_W-1:0] > GEST_GOODBYE) begin
                    rejected = 1'b1;
                end else begin
                    active_next  = s_tdata[GESTURE_W-1:0];
                    phase_next   = (s_tdata[GESTURE_W-1:0] == GEST_CLOSE) ? PH_CLOSE
                                                                           : PH_OPEN;
                    step_next    = '0;
                    mod3_next    = '0;
                    repeat_next  = '0;
                    running_next = 1'b1;
                end
            end else if (running_reg) begin
                if (closing || active_reg <= GEST_CLOSE || phase_reg == PH_OPEN) begin
                    // Open or close step: one degree toward the limit.
                    if (step_end) begin
                        limit_done = 1'b1;
                    end else begin
                        for (int f = 0; f < FINGER_COUNT; f++) begin
                            lim = closing ? lim_close[f] : rest[f];
                            if (closing && position_reg[f] < lim) begin
                                position_next[f] = position_reg[f] + 11'sd1;
                            end else if (!closing && position_reg[f] > lim) begin
                                position_next[f] = position_reg[f] - 11'sd1;
                            end
                            if (position_next[f] != lim) begin
                                all_there = 1'b0;
                            end
                        end
                        step_next  = step_inc[7:0];
                        mod3_next  = mod3_inc;
                        limit_done = all_there || (step_inc >= {1'b0, angle_span_reg});
                    end
                    if (closing || active_reg <= GEST_CLOSE) begin
                        if (limit_done) begin
                            finished = 1'b1;
                        end
                    end else if (limit_done) begin
                        if (angle_span_reg == '0) begin
                            finished = 1'b1;
                        end else begin
                            phase_next = PH_PATTERN;
                            step_next  = '0;
                            mod3_next  = '0;
                        end
                    end
                end else begin
                    // Pattern step: selected fingers move up one degree.
                    if (!step_end) begin
                        for (int f = 0; f < FINGER_COUNT; f++) begin
                            if (inc_mask[f] && position_reg[f] != POS_MAX) begin
                                position_next[f] = position_reg[f] + 11'sd1;
                            end
                        end
                        step_after = step_inc[7:0];
                        step_next  = step_inc[7:0];
                        mod3_next  = mod3_inc;
                    end
                    if (step_after >= angle_span_reg) begin
                        if (active_reg == GEST_GOODBYE && repeat_inc != 2'd0
                                && {30'd0, repeat_inc} < GOODBYE_REPEATS) begin
                            // Another round of open plus sweep.
                            repeat_next = repeat_inc;
                            phase_next  = PH_OPEN;
                            step_next   = '0;
                            mod3_next   = '0;
                        end else begin
                            finished = 1'b1;
                        end
                    end
                end
                if (finished) begin
                    running_next = 1'b0;
                    phase_next   = PH_IDLE;
                    step_next    = '0;
                    mod3_next    = '0;
                    repeat_next  = '0;
                end
            end
        end
    end

    // Pack the result item.
    always_comb begin
        out_data_next = '0;
        for (int f = 0; f < FINGER_COUNT; f++) begin
            out_data_next[f*ANGLE_W +: ANGLE_W] = clamp_angle(position_next[f]);
        end
        out_data_next[FINGER_COUNT*ANGLE_W]     = running_next;
        out_data_next[FINGER_COUNT*ANGLE_W + 1] = rejected;
        out_data_next[FINGER_COUNT*ANGLE_W + 2] = finished;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= RESET_START_ANGLE;
            angle_span_reg  <= RESET_ANGLE_SPAN;
            for (int f = 0; f < FINGER_COUNT; f++) begin
                offset_reg[f]   <= RESET_OFFSET[f];
                position_reg[f] <= rest_angle(RESET_START_ANGLE, RESET_OFFSET[f]);
            end
            active_reg    <= GEST_OPEN;
            phase_reg     <= PH_IDLE;
            step_reg      <= '0;
            mod3_reg      <= '0;
            repeat_reg    <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_START_ANGLE:   start_angle_reg <= cfg_wdata;
                    REG_ANGLE_SPAN:    angle_span_reg  <= cfg_wdata;
                    REG_OFFSET_THUMB:  offset_reg[0]   <= cfg_wdata[OFFSET_W-1:0];
                    REG_OFFSET_INDEX:  offset_reg[1]   <= cfg_wdata[OFFSET_W-1:0];
                    REG_OFFSET_MIDDLE: offset_reg[2]   <= cfg_wdata[OFFSET_W-1:0];
                    REG_OFFSET_RING:   offset_reg[3]   <= cfg_wdata[OFFSET_W-1:0];
                    REG_OFFSET_PINKY:  offset_reg[4]   <= cfg_wdata[OFFSET_W-1:0];
                    default:           ;
                endcase
            end
            for (int f = 0; f < FINGER_COUNT; f++) begin
                position_reg[f] <= position_next[f];
            end
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            mod3_reg    <= mod3_next;
            repeat_reg  <= repeat_next;
            running_reg <= running_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    // The phase is idle exactly when no gesture runs.
    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) == !running_reg)
        else $error("phase and running flag disagree");

    // An idle block keeps its counters cleared.
    a_idle_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (step_reg == '0 && repeat_reg == '0 && mod3_reg == '0))
        else $error("counters not cleared while idle");

    // The modulo-3 tracker never leaves its range.
    a_mod3_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mod3_reg != 2'd3)
        else $error("modulo-3 tracker out of range");

    // A result never reports both a rejection and a completion.
    a_rej_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !(rejected && finished))
        else $error("rejected and finished together");

    // A finishing tick leaves the block idle.
    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && finished) |=> !running_reg)
        else $error("gesture still running after finish");
`endif

endmodule
